@@ rtl/smpq_pkg.sv @@
`default_nettype none

package smpq_pkg;

    // Operation carried by one input word
    typedef enum logic {
        CMD_ENQUEUE = 1'b0,
        CMD_DEQUEUE = 1'b1
    } t_cmd;

    // Command from the controller to the datapath
    typedef struct packed {
        logic exec;
        t_cmd op;
    } t_dp_cmd;

endpackage

`default_nettype wire

@@ rtl/smpq_ctrl.sv @@
`default_nettype none

module smpq_ctrl
    import smpq_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    start,
    input  wire logic    i_command,
    output logic         busy,
    output logic         o_valid,
    output t_dp_cmd      o_dp_cmd
);

    typedef enum logic {
        S_IDLE,
        S_RESP
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;
    logic   r_strobe, n_strobe;
    logic   accept;

    assign accept = start && !r_busy;

    // Fire the datapath on the accepting edge
    assign o_dp_cmd.exec = accept;
    assign o_dp_cmd.op   = t_cmd'(i_command);

    always_comb begin
        n_state  = r_state;
        n_busy   = r_busy;
        n_strobe = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state  = S_RESP;
                    n_busy   = 1'b1;
                    n_strobe = 1'b1;
                end
            end
            S_RESP: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_busy   <= n_busy;
            r_strobe <= n_strobe;
        end
    end

    assign busy    = r_busy;
    assign o_valid = r_strobe;

    // An accepted word is answered on the very next cycle
    a_accept_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_valid)
        else $error("accepted word not answered");

    // A result strobe is never given twice in a row
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe repeated");

    // The strobe cycle is always a busy cycle, so no word is taken over a result
    a_strobe_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobed while not busy");

endmodule

`default_nettype wire

@@ rtl/smpq_datapath.sv @@
`default_nettype none

module smpq_datapath
    import smpq_pkg::*;
#(
    parameter int CAPACITY       = 16,
    parameter int PAYLOAD_WIDTH  = 32,
    parameter int PRIORITY_WIDTH = 16,
    parameter int COUNT_WIDTH    = 5
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire t_dp_cmd                   i_dp_cmd,
    input  wire logic [PAYLOAD_WIDTH-1:0]  i_payload,
    input  wire logic [PRIORITY_WIDTH-1:0] i_priority_value,
    output logic [PAYLOAD_WIDTH-1:0]       o_head_payload,
    output logic [PRIORITY_WIDTH-1:0]      o_head_priority,
    output logic [COUNT_WIDTH-1:0]         o_entry_count,
    output logic                           o_is_empty,
    output logic                           o_op_error
);

    localparam logic [COUNT_WIDTH-1:0] FullCount = COUNT_WIDTH'(CAPACITY);

    logic [PAYLOAD_WIDTH-1:0]  r_pay [CAPACITY];
    logic [PRIORITY_WIDTH-1:0] r_pri [CAPACITY];
    logic [PAYLOAD_WIDTH-1:0]  n_pay [CAPACITY];
    logic [PRIORITY_WIDTH-1:0] n_pri [CAPACITY];
    logic [CAPACITY-1:0]       r_valid, n_valid;
    logic [COUNT_WIDTH-1:0]    r_count, n_count;
    logic                      r_err, n_err;
    logic [CAPACITY-1:0]       le;
    logic                      full, empty;

    assign full  = (r_count == FullCount);
    assign empty = (r_count == '0);

    // Each slot compares the new priority at once; sorted order makes this a prefix
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            le[i] = r_valid[i] && (r_pri[i] <= i_priority_value);
        end
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_pay[i] = r_pay[i];
            n_pri[i] = r_pri[i];
        end
        n_valid = r_valid;
        n_count = r_count;
        n_err   = 1'b0;
        case (i_dp_cmd.op)
            CMD_ENQUEUE: begin
                if (full) begin
                    n_err = 1'b1;
                end else begin
                    // hold slots at or below the new priority, insert once, shift the rest up
                    if (!le[0]) begin
                        n_pay[0] = i_payload;
                        n_pri[0] = i_priority_value;
                    end
                    for (int i = 1; i < CAPACITY; i++) begin
                        if (!le[i]) begin
                            if (le[i-1]) begin
                                n_pay[i] = i_payload;
                                n_pri[i] = i_priority_value;
                            end else begin
                                n_pay[i] = r_pay[i-1];
                                n_pri[i] = r_pri[i-1];
                            end
                        end
                    end
                    n_valid = {r_valid[CAPACITY-2:0], 1'b1};
                    n_count = r_count + 1'b1;
                end
            end
            CMD_DEQUEUE: begin
                if (empty) begin
                    n_err = 1'b1;
                end else begin
                    // advance every slot one place toward the head
                    for (int i = 0; i < CAPACITY - 1; i++) begin
                        n_pay[i] = r_pay[i+1];
                        n_pri[i] = r_pri[i+1];
                    end
                    n_valid = {1'b0, r_valid[CAPACITY-1:1]};
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
                n_err = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.exec) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_pay[i] <= n_pay[i];
                r_pri[i] <= n_pri[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            r_err   <= 1'b0;
        end else if (i_dp_cmd.exec) begin
            r_valid <= n_valid;
            r_count <= n_count;
            r_err   <= n_err;
        end
    end

    assign o_head_payload  = r_valid[0] ? r_pay[0] : '0;
    assign o_head_priority = r_valid[0] ? r_pri[0] : '0;
    assign o_entry_count   = r_count;
    assign o_is_empty      = empty;
    assign o_op_error      = r_err;

    // Occupancy bits and the count must agree
    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == 32'(r_count))
        else $error("count and occupancy disagree");

    // The head slot is the one that stays sorted ahead of the next
    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid[0] && r_valid[1]) |-> (r_pri[0] <= r_pri[1]))
        else $error("head entry out of order");

    // An enqueue into a full queue leaves the count alone and flags
    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_dp_cmd.exec && i_dp_cmd.op == CMD_ENQUEUE && full)
            |=> (r_err && r_count == FullCount))
        else $error("full enqueue not dropped");

endmodule

`default_nettype wire

@@ rtl/stable_min_priority_queue.sv @@
// Channel  | Direction | Handshake            | Word
// ---------+-----------+----------------------+-------------------------------------------
// command  | in        | start high, busy low | i_command, i_payload, i_priority_value
// result   | out       | o_valid, one cycle   | o_head_payload, o_head_priority,
//          |           |                      | o_entry_count, o_is_empty, o_op_error
//
// For each accepted word, the sorted shift-register slots update on the accepting
// edge, and the result word is strobed on the following cycle while busy is high.
// Every slot compares the new priority in parallel, so the insert position is found
// at once whatever the fill level.
// Reset (i_rst_n low at a clock edge) empties the queue and drops any pending result.
// The receiver cannot stall: the result is valid for exactly the strobe cycle.
`default_nettype none

module stable_min_priority_queue
    import smpq_pkg::*;
#(
    parameter int CAPACITY       = 16,
    parameter int PAYLOAD_WIDTH  = 32,
    parameter int PRIORITY_WIDTH = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_command,
    input  wire logic [PAYLOAD_WIDTH-1:0]      i_payload,
    input  wire logic [PRIORITY_WIDTH-1:0]     i_priority_value,
    output logic                               o_valid,
    output logic [PAYLOAD_WIDTH-1:0]           o_head_payload,
    output logic [PRIORITY_WIDTH-1:0]          o_head_priority,
    output logic [$clog2(CAPACITY+1)-1:0]      o_entry_count,
    output logic                               o_is_empty,
    output logic                               o_op_error
);

    // Count must reach CAPACITY itself
    localparam int CountWidth = $clog2(CAPACITY + 1);

    t_dp_cmd dp_cmd;

    // Controller: accept a word, then strobe its result for one cycle
    smpq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_command (i_command),
        .busy      (busy),
        .o_valid   (o_valid),
        .o_dp_cmd  (dp_cmd)
    );

    // Datapath: sorted slots, occupancy, count and error flag
    smpq_datapath #(
        .CAPACITY       (CAPACITY),
        .PAYLOAD_WIDTH  (PAYLOAD_WIDTH),
        .PRIORITY_WIDTH (PRIORITY_WIDTH),
        .COUNT_WIDTH    (CountWidth)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_dp_cmd         (dp_cmd),
        .i_payload        (i_payload),
        .i_priority_value (i_priority_value),
        .o_head_payload   (o_head_payload),
        .o_head_priority  (o_head_priority),
        .o_entry_count    (o_entry_count),
        .o_is_empty       (o_is_empty),
        .o_op_error       (o_op_error)
    );

endmodule

`default_nettype wire
